// ===== rtl/sip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash package
// Shared types, initialization constants and register map of the SipHash MAC.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int WORD_W  = 64;
  localparam int ADDR_W  = 5;
  localparam int ROUND_W = 4;
  localparam int CNT_W   = ROUND_W + 1;

  localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;

  localparam logic [7:0] FIN_PAD = 8'hff;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_COMP     = 2'd2;
  localparam logic [1:0] REG_FIN      = 2'd3;

  localparam logic [ROUND_W-1:0] COMP_RESET = 4'd2;
  localparam logic [ROUND_W-1:0] FIN_RESET  = 4'd4;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef logic [3:0][WORD_W-1:0] state_t;

  typedef struct packed {
    logic [WORD_W-1:0]  key_low;
    logic [WORD_W-1:0]  key_high;
    logic [ROUND_W-1:0] comp_rounds;
    logic [ROUND_W-1:0] fin_rounds;
    logic               restart;
  } cfg_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
    rotl = (x << r) | (x >> (WORD_W - r));
  endfunction

endpackage

// ===== rtl/sip_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash stream interfaces
// Valid/ready channels for message items and hash results.
// ----------------------------------------------------------------------------
interface sip_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface sip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== rtl/siphash_streaming_mac_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash streaming MAC
// Keyed SipHash-c-d over a byte stream, one shared half-round datapath.
// ----------------------------------------------------------------------------
//
//   channel   | dir | payload                    | handshake
//   ----------+-----+----------------------------+-------------------------
//   msg_in    | in  | func (1), data_byte (8)    | valid / ready
//   hash_out  | out | hash_value (64)            | valid / ready
//   apb       | in  | paddr (5), pwdata (64)     | psel / penable, pready=1
//
// A byte that does not complete a word is stored in the partial word. A byte
// that completes a word runs the c compression rounds, and a finish item those
// and the d finalization rounds, at half of a SipRound per cycle on one unit.
// Reset (synchronous, rst high) loads the state for the all-zero key.
// msg_in is not ready while a word or finish is in the rounds; a finish waits
// in its last step while an earlier hash still sits unread in the output reg.
// A key write holds msg_in off in its access cycle and in the cycle after,
// in which the state is reloaded from the new key if the unit is idle.
// ----------------------------------------------------------------------------
module siphash_streaming_mac_unit (
  input  logic                       clk,
  input  logic                       rst,
  sip_in_if.sink                     msg_in,
  sip_out_if.source                  hash_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sip_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a byte or finish
  localparam logic [1:0] ST_COMP = 2'd1;  // compression rounds on a word
  localparam logic [1:0] ST_FIN  = 2'd2;  // finalization rounds
  localparam logic [1:0] ST_DONE = 2'd3;  // hand the hash to the output reg

  sip_pkg::cfg_t               cfg;
  sip_pkg::state_t             v;
  sip_pkg::state_t             round_v;
  sip_pkg::state_t             start_v;
  logic [1:0]                  state;
  logic [sip_pkg::CNT_W-1:0]   cnt;
  logic [63:0]                 word;
  logic [55:0]                 partial;
  logic [2:0]                  pos;
  logic [7:0]                  len;
  logic                        finishing;
  logic                        reload;
  logic                        out_valid;
  logic [63:0]                 out_data;
  logic                        accept;
  logic [63:0]                 full_word;
  logic [63:0]                 fin_word;

  sip_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Even counts run the first half of a SipRound, odd counts the second.
  sip_half_round u_round (
    .sel    (cnt[0]),
    .v      (v),
    .v_next (round_v)
  );

  // Key-derived initial state of a message.
  assign start_v[0] = sip_pkg::SIP_C0 ^ cfg.key_low;
  assign start_v[1] = sip_pkg::SIP_C1 ^ cfg.key_high;
  assign start_v[2] = sip_pkg::SIP_C2 ^ cfg.key_low;
  assign start_v[3] = sip_pkg::SIP_C3 ^ cfg.key_high;

  // The key register takes its new value at the write edge, so an idle unit
  // reloads its state in the cycle after. Input is held off in the write and
  // reload cycles so that a restart never meets a byte.
  assign msg_in.ready = (state == ST_IDLE) && !cfg.restart && !reload;
  assign accept       = msg_in.valid && msg_in.ready;

  // Word completed by the eighth byte, and the padded tail word of a finish.
  assign full_word = {msg_in.data_byte, partial};
  assign fin_word  = {len, partial};

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      v[0]      <= sip_pkg::SIP_C0;
      v[1]      <= sip_pkg::SIP_C1;
      v[2]      <= sip_pkg::SIP_C2;
      v[3]      <= sip_pkg::SIP_C3;
      partial   <= '0;
      pos       <= '0;
      len       <= '0;
      finishing <= 1'b0;
      reload    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      reload <= cfg.restart;
      // The done step refills the output register itself when it is taken.
      if (out_valid && hash_out.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (reload) begin
            v       <= start_v;
            partial <= '0;
            pos     <= '0;
            len     <= '0;
          end else if (accept) begin
            if (msg_in.func == sip_pkg::FUNC_FINISH) begin
              // Absorb the tail word, then finalize.
              word      <= fin_word;
              v[3]      <= v[3] ^ fin_word;
              finishing <= 1'b1;
              cnt       <= '0;
              state     <= ST_COMP;
            end else if (pos == 3'd7) begin
              word      <= full_word;
              v[3]      <= v[3] ^ full_word;
              partial   <= '0;
              pos       <= '0;
              len       <= len + 8'd1;
              finishing <= 1'b0;
              cnt       <= '0;
              state     <= ST_COMP;
            end else begin
              partial[pos*8 +: 8] <= msg_in.data_byte;
              pos                 <= pos + 3'd1;
              len                 <= len + 8'd1;
            end
          end
        end
        ST_COMP: begin
          if (cnt == {cfg.comp_rounds, 1'b0}) begin
            v[0] <= v[0] ^ word;
            cnt  <= '0;
            if (finishing) begin
              v[2]  <= v[2] ^ {56'd0, sip_pkg::FIN_PAD};
              state <= ST_FIN;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            v   <= round_v;
            cnt <= cnt + 1'b1;
          end
        end
        ST_FIN: begin
          if (cnt == {cfg.fin_rounds, 1'b0}) begin
            state <= ST_DONE;
          end else begin
            v   <= round_v;
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          // Wait until the output register is free, then start a new message.
          if (!out_valid || hash_out.ready) begin
            out_data  <= v[0] ^ v[1] ^ v[2] ^ v[3];
            out_valid <= 1'b1;
            v         <= start_v;
            partial   <= '0;
            pos       <= '0;
            len       <= '0;
            finishing <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sip_half_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash half round
// One half of a SipRound; sel picks the first or second half.
// ----------------------------------------------------------------------------
module sip_half_round (
  input  logic            sel,
  input  sip_pkg::state_t v,
  output sip_pkg::state_t v_next
);

  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] sx;
  logic [63:0] sy;
  logic [63:0] nb;
  logic [63:0] nd;

  // The second half is the first with v0 and v2 swapped and other rotations.
  assign x  = sel ? v[2] : v[0];
  assign y  = sel ? v[0] : v[2];
  assign sx = x + v[1];
  assign sy = y + v[3];
  assign nb = (sel ? sip_pkg::rotl(v[1], 17) : sip_pkg::rotl(v[1], 13)) ^ sx;
  assign nd = (sel ? sip_pkg::rotl(v[3], 21) : sip_pkg::rotl(v[3], 16)) ^ sy;

  always_comb begin
    v_next[1] = nb;
    v_next[3] = nd;
    if (sel) begin
      v_next[2] = sip_pkg::rotl(sx, 32);
      v_next[0] = sy;
    end else begin
      v_next[0] = sip_pkg::rotl(sx, 32);
      v_next[2] = sy;
    end
  end

endmodule

// ===== rtl/sip_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash register file
// APB-style key and round count registers with read back.
// ----------------------------------------------------------------------------
module sip_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sip_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  output sip_pkg::cfg_t              cfg
);

  logic                        wr;
  logic [1:0]                  idx;
  logic [63:0]                 key_low;
  logic [63:0]                 key_high;
  logic [sip_pkg::ROUND_W-1:0] comp_rounds;
  logic [sip_pkg::ROUND_W-1:0] fin_rounds;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[sip_pkg::ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      comp_rounds <= sip_pkg::COMP_RESET;
      fin_rounds  <= sip_pkg::FIN_RESET;
    end else if (wr) begin
      case (idx)
        sip_pkg::REG_KEY_LOW:  key_low     <= pwdata;
        sip_pkg::REG_KEY_HIGH: key_high    <= pwdata;
        sip_pkg::REG_COMP:     comp_rounds <= pwdata[sip_pkg::ROUND_W-1:0];
        sip_pkg::REG_FIN:      fin_rounds  <= pwdata[sip_pkg::ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sip_pkg::REG_KEY_LOW:  prdata = key_low;
      sip_pkg::REG_KEY_HIGH: prdata = key_high;
      sip_pkg::REG_COMP:     prdata = {60'd0, comp_rounds};
      sip_pkg::REG_FIN:      prdata = {60'd0, fin_rounds};
      default:               prdata = '0;
    endcase
  end

  assign cfg.key_low     = key_low;
  assign cfg.key_high    = key_high;
  assign cfg.comp_rounds = comp_rounds;
  assign cfg.fin_rounds  = fin_rounds;
  // A key write requests a restart of the message from the new key-derived state.
  assign cfg.restart     = wr && (idx == sip_pkg::REG_KEY_LOW || idx == sip_pkg::REG_KEY_HIGH);

endmodule
